FILE: sv/pidaw_pkg.sv
// pidaw_pkg: shared constants, register indexes and types for the pid controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pidaw_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ClipW = 2;

  localparam logic [CfgIdxW-1:0] RegGainP = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAlpha = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDriveMax = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDriveMin = 3'd5;

  localparam logic [ClipW-1:0] ClipNone = 2'd0;
  localparam logic [ClipW-1:0] ClipMax = 2'd1;
  localparam logic [ClipW-1:0] ClipMin = 2'd2;

  localparam logic [DataW-1:0] GainPReset = 32'h0001_0000;
  localparam logic [AlphaW-1:0] AlphaOne = 17'h1_0000;

  typedef struct packed {
    logic signed [DataW-1:0] target;
    logic signed [DataW-1:0] measured;
    logic [DataW-1:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic [ClipW-1:0] clip_state;
  } out_item_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -66'sd2147483648) return 32'sh8000_0000;
    return x[DataW-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: sv/pidaw_if.sv
// pidaw_if: valid/ready channel carrying one payload
// depends on pidaw_pkg only through the payload type given as a parameter
`timescale 1ns / 1ps
`default_nettype none
interface pidaw_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/pid_controller_antiwindup.sv
// pid_controller_antiwindup: top level, serial multiplier/divider datapath
// depends on pidaw_pkg and pidaw_if
`timescale 1ns / 1ps
`default_nettype none
// PID controller with back-calculation anti-windup in Q16.16. One request is
// taken at a time; the datapath is a single shift-and-add multiplier and a
// restoring divider, both radix-2, retiring one bit per cycle. A request runs
// through up to eight operations (integral product, slope divide, two EMA
// products, three gain products, back-calculation divide); a multiply takes
// 48 steps plus launch and finish, and a divide 64 steps plus launch and
// finish, all on that shared serial unit. The result sits in an output
// register; a new request is taken once the previous result has been taken.
module pid_controller_antiwindup (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pidaw_if.sink   in_if,
  pidaw_if.source out_if,
  input  wire logic cfg_we_i,
  input  wire logic [pidaw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [pidaw_pkg::DataW-1:0] cfg_data_i
);
  typedef enum logic [8:0] {
    StIdle = 9'b000000001, StInt = 9'b000000010, StSlope = 9'b000000100,
    StEmaA = 9'b000001000, StEmaB = 9'b000010000, StKp = 9'b000100000,
    StKi   = 9'b001000000, StKd = 9'b010000000, StBack = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic signed [31:0] kp_q, ki_q, kd_q, hi_q, lo_q;
  logic [16:0] alpha_q;
  logic signed [31:0] isum_q, lerr_q, slope_q;
  logic signed [31:0] err_q, raw_q, deriv_q;
  logic [31:0] dt_q;
  logic signed [65:0] acc_q;     // running sum of terms
  logic dskip_q;
  logic out_v_q;
  pidaw_pkg::out_item_t out_q;

  // serial unit: multiplier a*b (unsigned magnitudes) or divider n/d
  logic [63:0] ma_q;             // multiplicand (shifting left)
  logic [47:0] mb_q;             // multiplier bits (shifting right)
  logic [127:0] prod_q;
  logic [63:0] rem_q, quo_q, num_q, den_q;
  logic neg_q;
  logic [6:0] cnt_q;
  logic busy_q, isdiv_q, done;

  assign in_if.ready = (state_q == StIdle) && !out_v_q;
  assign out_if.valid = out_v_q;
  assign out_if.payload = out_q;

  // helpers
  function automatic logic [63:0] mag64(input logic signed [65:0] x);
    return x[65] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [65:0] rnd(input logic [127:0] p, input logic n);
    logic signed [65:0] v;
    // floor((s*p + 32768)/65536) on signed value
    if (!n) v = 66'((p + 128'd32768) >> 16);
    else if (p <= 128'd32768) v = 66'sd0;
    else v = -66'(((p - 128'd32769) >> 16)) - 66'sd1;
    return v;
  endfunction

  function automatic logic signed [31:0] ssat(input logic [63:0] m, input logic n);
    if (n) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-m);
    return (m >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
  endfunction

  logic signed [65:0] rres;
  logic signed [31:0] sres;
  logic signed [31:0] err_in;
  logic signed [32:0] esum, ediff;
  logic signed [65:0] outv;
  logic [16:0] alpha_c;
  logic signed [65:0] ema_sum;   // alpha*raw plus the second EMA product
  logic signed [65:0] ema_rnd;
  assign alpha_c = (alpha_q > pidaw_pkg::AlphaOne) ? pidaw_pkg::AlphaOne : alpha_q;
  assign err_in = pidaw_pkg::sat32(66'(in_if.payload.target) - 66'(in_if.payload.measured));
  assign esum = 33'(err_q) + 33'(lerr_q);
  assign ediff = 33'(err_q) - 33'(lerr_q);
  assign rres = rnd(prod_q, neg_q);
  assign sres = ssat(quo_q, neg_q);
  assign outv = acc_q;
  assign done = busy_q && (cnt_q == 7'd0);
  assign ema_sum = acc_q + (neg_q ? -$signed(66'(prod_q)) : $signed(66'(prod_q)));
  assign ema_rnd = rnd(128'(mag64(ema_sum)), ema_sum[65]);

  // operation launch
  logic go, go_div;
  logic [63:0] go_a, go_n, go_d;
  logic [47:0] go_b;
  logic go_neg;
  logic signed [65:0] exc;

  always_comb begin
    state_d = state_q;
    go = 1'b0; go_div = 1'b0; go_a = '0; go_b = '0; go_n = '0; go_d = 64'd1;
    go_neg = 1'b0; exc = '0;
    unique case (state_q)
      StIdle: if (in_if.valid && in_if.ready) begin
        state_d = StInt;
      end
      StInt: if (!busy_q) begin
        go = 1'b1; go_a = mag64(66'(esum)); go_b = 48'(dt_q);
      end else if (done) begin
        state_d = StSlope;
      end
      StSlope: if (dskip_q) state_d = StKp;
      else if (!busy_q) begin
        go = 1'b1; go_div = 1'b1; go_n = mag64(66'(ediff)) << 16;
        go_d = 64'(dt_q); go_neg = ediff[32];
      end else if (done) state_d = StEmaA;
      StEmaA: if (!busy_q) begin
        go = 1'b1; go_a = mag64(66'(raw_q)); go_b = 48'(alpha_c); go_neg = raw_q[31];
      end else if (done) state_d = StEmaB;
      StEmaB: if (!busy_q) begin
        go = 1'b1; go_a = mag64(66'(slope_q));
        go_b = 48'(pidaw_pkg::AlphaOne - alpha_c); go_neg = slope_q[31];
      end else if (done) state_d = StKp;
      StKp: if (!busy_q) begin
        go = 1'b1; go_a = mag64(66'(err_q)); go_b = 48'(mag64(66'(kp_q)));
        go_neg = err_q[31] ^ kp_q[31];
      end else if (done) state_d = StKi;
      StKi: if (!busy_q) begin
        go = 1'b1; go_a = mag64(66'(isum_q)); go_b = 48'(mag64(66'(ki_q)));
        go_neg = isum_q[31] ^ ki_q[31];
      end else if (done) state_d = StKd;
      StKd: if (!busy_q) begin
        go = 1'b1; go_a = mag64(66'(deriv_q)); go_b = 48'(mag64(66'(kd_q)));
        go_neg = deriv_q[31] ^ kd_q[31];
      end else if (done) state_d = StBack;
      StBack: begin
        if (outv > 66'(hi_q)) exc = outv - 66'(hi_q);
        else exc = 66'(lo_q) - outv;
        if (!busy_q && ki_q != 0 && (outv > 66'(hi_q) || outv < 66'(lo_q))) begin
          go = 1'b1; go_div = 1'b1;
          go_n = ((exc > 66'sh8000_0000_0000) ? 64'h8000_0000_0000 : 64'(exc)) << 16;
          go_d = mag64(66'(ki_q)); go_neg = ki_q[31];
        end else if (!busy_q || done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // serial unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (go) begin
      busy_q <= 1'b1; cnt_q <= go_div ? 7'd64 : 7'd48;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  logic [64:0] trial;
  assign trial = {rem_q, num_q[63]} - {1'b0, den_q};
  always_ff @(posedge clk_i) begin
    if (go) begin
      isdiv_q <= go_div; neg_q <= go_neg; ma_q <= go_a; mb_q <= go_b;
      prod_q <= '0; num_q <= go_n; den_q <= go_d; rem_q <= '0; quo_q <= '0;
    end else if (busy_q && cnt_q != 0) begin
      if (isdiv_q) begin
        // one restoring step per cycle
        if (!trial[64]) begin
          rem_q <= trial[63:0]; quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= {rem_q[62:0], num_q[63]}; quo_q <= {quo_q[62:0], 1'b0};
        end
        num_q <= {num_q[62:0], 1'b0};
      end else begin
        if (mb_q[0]) prod_q <= prod_q + 128'(ma_q);
        ma_q <= {ma_q[62:0], 1'b0};
        mb_q <= {1'b0, mb_q[47:1]};
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= pidaw_pkg::GainPReset; ki_q <= '0; kd_q <= '0;
      alpha_q <= pidaw_pkg::AlphaOne; hi_q <= 32'sh7FFF_FFFF; lo_q <= 32'sh8000_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pidaw_pkg::RegGainP: kp_q <= cfg_data_i;
        pidaw_pkg::RegGainI: ki_q <= cfg_data_i;
        pidaw_pkg::RegGainD: kd_q <= cfg_data_i;
        pidaw_pkg::RegAlpha: alpha_q <= cfg_data_i[16:0];
        pidaw_pkg::RegDriveMax: hi_q <= cfg_data_i;
        pidaw_pkg::RegDriveMin: lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // controller state and sequencing
  logic [63:0] imag;
  assign imag = (prod_q[63:0] + 64'h1_0000) >> 17;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; isum_q <= '0; lerr_q <= '0; slope_q <= '0;
      out_v_q <= 1'b0;
      err_q <= '0; dt_q <= '0; dskip_q <= 1'b0; deriv_q <= '0; acc_q <= '0;
      raw_q <= '0; out_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_if.valid && out_if.ready) out_v_q <= 1'b0;
      if (state_q == StIdle && in_if.valid && in_if.ready) begin
        err_q <= err_in; dt_q <= in_if.payload.step_time;
        dskip_q <= (in_if.payload.step_time == 0) || (lerr_q == 0);
        deriv_q <= '0; acc_q <= '0;
      end
      if (done) begin
        unique case (state_q)
          StInt: begin
            isum_q <= pidaw_pkg::sat32(66'(isum_q) + 66'(ssat(imag, esum[32])));
          end
          StSlope: raw_q <= sres;
          StEmaA: acc_q <= neg_q ? -66'(prod_q) : 66'(prod_q);
          StEmaB: begin
            deriv_q <= pidaw_pkg::sat32(ema_rnd);
            slope_q <= pidaw_pkg::sat32(ema_rnd);
            acc_q <= '0;
          end
          StKp, StKi, StKd: acc_q <= acc_q + rres;
          StBack: isum_q <= outv > 66'(hi_q) ?
                   pidaw_pkg::sat32(66'(isum_q) - 66'(sres)) :
                   pidaw_pkg::sat32(66'(isum_q) + 66'(sres));
          default: ;
        endcase
      end
      // previous error kept until the slope has been formed
      if (state_q == StKp && done) lerr_q <= err_q;
      if (state_q == StBack && state_d == StIdle) begin
        out_v_q <= 1'b1;
        if (outv > 66'(hi_q)) begin
          out_q.drive <= hi_q; out_q.clip_state <= pidaw_pkg::ClipMax;
        end else if (outv < 66'(lo_q)) begin
          out_q.drive <= lo_q; out_q.clip_state <= pidaw_pkg::ClipMin;
        end else begin
          out_q.drive <= outv[31:0]; out_q.clip_state <= pidaw_pkg::ClipNone;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/pidaw_checker.sv
// pidaw_checker: port-level checks on the pid controller, bound to the top level
// depends on pidaw_pkg and pidaw_if
`timescale 1ns / 1ps
`default_nettype none
module pidaw_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] clip
);
  a_clip_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (clip == pidaw_pkg::ClipNone || clip == pidaw_pkg::ClipMax ||
                   clip == pidaw_pkg::ClipMin)) else $error("bad clip code");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind pid_controller_antiwindup pidaw_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .clip(out_if.payload.clip_state)
);
`default_nettype wire

FILE: dv/pid_controller_antiwindup_tb.sv
// pid_controller_antiwindup_tb: self-checking bench for the pid controller with anti-windup
// depends on pidaw_pkg, pidaw_if and the pid_controller_antiwindup top level
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_antiwindup_tb;
  import pidaw_pkg::*;

  localparam int unsigned WatchdogLimit = 40000;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned ItemsPerPhase = 100;

  typedef enum logic [1:0] {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [CfgIdxW-1:0] idx;
    logic [DataW-1:0] a;       // target, or register value for a write row
    logic [DataW-1:0] b;       // measured
    logic [DataW-1:0] dt;      // step time
    bit has_exp;
    out_item_t exp;
  } stim_row_t;

  typedef struct {
    bit has_exp;
    out_item_t exp;
  } typed_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  pidaw_if #(.payload_t(in_item_t)) req_if ();
  pidaw_if #(.payload_t(out_item_t)) drv_if ();

  pid_controller_antiwindup uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(req_if.sink),
    .out_if(drv_if.source),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the controller registers and state
  logic signed [DataW-1:0] gain_p_q, gain_i_q, gain_d_q, drive_max_q, drive_min_q;
  logic [AlphaW-1:0] alpha_q;
  longint integ_q, prev_err_q, slope_q;

  out_item_t expected_drives[$];
  typed_exp_t typed_q[$];
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // value from magnitude and sign, saturated to 32 bits
  function automatic longint mag_to_s32(logic [65:0] mag, bit neg);
    if (neg) return (mag >= 66'h8000_0000) ? -64'sd2147483648 : -longint'(mag[62:0]);
    return (mag >= 66'h7FFF_FFFF) ? 64'sd2147483647 : longint'(mag[62:0]);
  endfunction

  // floor((x + half) / one) in Q16
  function automatic longint q16_round(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint windup_quot(longint excess, longint ki);
    logic [65:0] e, k;
    e = excess;
    k = (ki < 0) ? -ki : ki;
    if (e > (66'd1 << 47)) e = 66'd1 << 47;
    return mag_to_s32((e << 16) / k, ki < 0);
  endfunction

  // next drive from one request, advances the shadow state
  function automatic out_item_t pid_drive_next(in_item_t it);
    longint err, sum, diff, raw, deriv, outv, kp, ki, kd, hi, lo, alpha;
    logic [65:0] mag, dt;
    out_item_t r;
    kp = longint'(gain_p_q);
    ki = longint'(gain_i_q);
    kd = longint'(gain_d_q);
    hi = longint'(drive_max_q);
    lo = longint'(drive_min_q);
    alpha = (alpha_q > AlphaOne) ? 65536 : longint'(alpha_q);
    dt = {34'd0, it.step_time};
    err = clamp32(longint'($signed(it.target)) - longint'($signed(it.measured)));
    // trapezoidal integration on the magnitude
    sum = err + prev_err_q;
    mag = (sum < 0) ? -sum : sum;
    mag = (dt * mag + 66'h1_0000) >> 17;
    integ_q = clamp32(integ_q + mag_to_s32(mag, sum < 0));
    // derivative skipped when no time has passed or the last error was zero
    deriv = 0;
    if (dt != 0 && prev_err_q != 0) begin
      diff = err - prev_err_q;
      mag = (diff < 0) ? -diff : diff;
      raw = mag_to_s32((mag << 16) / dt, diff < 0);
      deriv = clamp32(q16_round(alpha * raw + (65536 - alpha) * slope_q));
      slope_q = deriv;
    end
    prev_err_q = err;
    outv = q16_round(kp * err) + q16_round(ki * integ_q) + q16_round(kd * deriv);
    r.clip_state = ClipNone;
    // upper clamp tested first, also when the clamps are inverted
    if (outv > hi) begin
      if (ki != 0) integ_q = clamp32(integ_q - windup_quot(outv - hi, ki));
      outv = hi;
      r.clip_state = ClipMax;
    end else if (outv < lo) begin
      if (ki != 0) integ_q = clamp32(integ_q + windup_quot(lo - outv, ki));
      outv = lo;
      r.clip_state = ClipMin;
    end
    r.drive = outv[31:0];
    return r;
  endfunction

  // request and result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    out_item_t pred, got;
    typed_exp_t te;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        pred = pid_drive_next(req_if.payload);
        te = typed_q.pop_front();
        expected_drives.push_back(te.has_exp ? te.exp : pred);
      end
      if (drv_if.valid && drv_if.ready) begin
        got = drv_if.payload;
        if (expected_drives.size() == 0) begin
          $display("%0t: unexpected result drive=%h clip=%0d", $time, got.drive,
                   got.clip_state);
          fail_cnt++;
        end else begin
          pred = expected_drives.pop_front();
          if (got.drive !== pred.drive) begin
            $display("%0t: drive mismatch expected %h actual %h", $time, pred.drive,
                     got.drive);
            fail_cnt++;
          end
          if (got.clip_state !== pred.clip_state) begin
            $display("%0t: clip_state mismatch expected %0d actual %0d", $time,
                     pred.clip_state, got.clip_state);
            fail_cnt++;
          end
        end
      end
      // watchdog on cycles with no handshake on either side
      if ((req_if.valid && req_if.ready) || (drv_if.valid && drv_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("pid_controller_antiwindup_tb: FAIL");
        $finish;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    drv_if.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    while (expected_drives.size() != 0 || typed_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      RegGainP: gain_p_q = val;
      RegGainI: gain_i_q = val;
      RegGainD: gain_d_q = val;
      RegAlpha: alpha_q = val[AlphaW-1:0];
      RegDriveMax: drive_max_q = val;
      RegDriveMin: drive_min_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_request(logic [DataW-1:0] tgt, logic [DataW-1:0] meas,
                              logic [DataW-1:0] dt, bit has_exp, out_item_t exp);
    typed_exp_t te;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    te.has_exp = has_exp;
    te.exp = exp;
    typed_q.push_back(te);
    req_if.valid = 1'b1;
    req_if.payload.target = tgt;
    req_if.payload.measured = meas;
    req_if.payload.step_time = dt;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  // mostly small magnitudes so the loop stays in range, sometimes extremes
  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom();
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  stim_row_t dir_rows[$];
  out_item_t none_exp = '0;

  function automatic stim_row_t item_row(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                         logic [DataW-1:0] dt, bit has_exp,
                                         logic [DataW-1:0] ed, logic [ClipW-1:0] ec);
    stim_row_t r;
    r.kind = RowItem;
    r.idx = '0;
    r.a = a;
    r.b = b;
    r.dt = dt;
    r.has_exp = has_exp;
    r.exp.drive = ed;
    r.exp.clip_state = ec;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] v);
    stim_row_t r;
    r = item_row(v, '0, '0, 1'b0, '0, ClipNone);
    r.kind = RowCfg;
    r.idx = idx;
    return r;
  endfunction

  initial begin
    logic [DataW-1:0] lo_v, hi_v;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    drv_if.ready = 1'b0;
    gain_p_q = GainPReset;
    gain_i_q = '0;
    gain_d_q = '0;
    alpha_q = AlphaOne;
    drive_max_q = 32'h7FFF_FFFF;
    drive_min_q = 32'h8000_0000;
    integ_q = 0;
    prev_err_q = 0;
    slope_q = 0;

    // after reset the drive is just the error, unclamped
    dir_rows = '{
      item_row(32'h0, 32'h0, 32'h0, 1, 32'h0, ClipNone),
      item_row(32'h0005_0000, 32'h0002_0000, 32'h0001_0000, 1, 32'h0003_0000, ClipNone),
      item_row(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, ClipNone),
      item_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1, 32'h8000_0000, ClipNone),
      item_row(32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 1, 32'hFFFF_FFFF, ClipNone),
      cfg_row(RegGainI, 32'h0000_8000),
      cfg_row(RegGainD, 32'h0000_4000),
      cfg_row(RegAlpha, 32'h0001_FFFF),                // weight above one
      item_row(32'h0002_0000, 32'h0, 32'h0000_8000, 0, '0, ClipNone),
      item_row(32'h0004_0000, 32'h0, 32'h0, 0, '0, ClipNone),   // no elapsed time
      item_row(32'h0003_0000, 32'h0, 32'h0001_0000, 0, '0, ClipNone),
      cfg_row(RegDriveMax, 32'h0001_0000),
      cfg_row(RegDriveMin, 32'hFFFF_0000),
      item_row(32'h0010_0000, 32'h0, 32'h0001_0000, 0, '0, ClipNone),
      item_row(32'hFFF0_0000, 32'h0, 32'h0001_0000, 0, '0, ClipNone),
      cfg_row(RegGainI, 32'h0),                       // clamp without back-calculation
      item_row(32'h0010_0000, 32'h0, 32'h0001_0000, 0, '0, ClipNone),
      cfg_row(RegDriveMax, 32'hFFFF_0000),            // inverted clamps
      cfg_row(RegDriveMin, 32'h0001_0000),
      item_row(32'h0, 32'h0, 32'h0001_0000, 0, '0, ClipNone),
      cfg_row(RegGainP, 32'h8000_0000),
      cfg_row(RegAlpha, 32'h0),
      item_row(32'h7FFF_FFFF, 32'h0, 32'h0000_0100, 0, '0, ClipNone)
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    snd_idle_pct = 20;
    rcv_idle_pct = 75;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) reg_write(dir_rows[i].idx, dir_rows[i].a);
      else send_request(dir_rows[i].a, dir_rows[i].b, dir_rows[i].dt,
                        dir_rows[i].has_exp, dir_rows[i].exp);
    end

    for (int p = 0; p < RandPhases; p++) begin
      // idling pattern per third of the random run
      if (p < 3) begin
        snd_idle_pct = 20;
        rcv_idle_pct = 75;
      end else if (p < 6) begin
        snd_idle_pct = 75;
        rcv_idle_pct = 20;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      reg_write(RegGainP, (p == 0) ? 32'h7FFF_FFFF : rand_gain());
      reg_write(RegGainI, (p == 1) ? 32'h8000_0000 : rand_gain());
      reg_write(RegGainD, (p == 2) ? 32'h7FFF_FFFF : rand_gain());
      case (p % 4)
        0: reg_write(RegAlpha, 32'h0);
        1: reg_write(RegAlpha, 32'h0001_0000);
        2: reg_write(RegAlpha, $urandom_range(17'h1_0001, 17'h1_FFFF));
        default: reg_write(RegAlpha, $urandom_range(0, 17'h1_0000));
      endcase
      if (p == RandPhases - 1) begin
        hi_v = 32'h7FFF_FFFF;
        lo_v = 32'h8000_0000;
      end else begin
        hi_v = $urandom_range(0, 32'h0020_0000);
        lo_v = -$urandom_range(0, 32'h0020_0000);
        if (p == 4) {hi_v, lo_v} = {lo_v, hi_v};
      end
      reg_write(RegDriveMax, hi_v);
      reg_write(RegDriveMin, lo_v);
      for (int n = 0; n < ItemsPerPhase; n++)
        send_request(rand_value(), rand_value(), rand_step(), 1'b0, none_exp);
    end

    while (expected_drives.size() != 0 || typed_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_cnt == 0 && expected_drives.size() == 0) begin
      $display("pid_controller_antiwindup_tb: PASS");
    end else begin
      $display("pid_controller_antiwindup_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
